### hdl/dsbp_pkg.sv
// Shared types, character codes and size constants for the decimal string parser.
// Used by dsbp_step and decimal_string_to_bcd_parser_top; depends on nothing.
package dsbp_pkg;

    // Width of the significant digit counter; the digit limit is 2^COUNT_BITS - 1.
    localparam int COUNT_BITS = 16;

    // Magnitude limits for the fraction scale and the exponent.
    localparam int MAG_BITS = 15;

    // ASCII codes that the grammar looks at.
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_EXP   = 8'h45;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Parser phases, in the order the text runs through them.
    typedef enum logic [3:0] {
        PH_SKIP = 4'd0,
        PH_NUM0 = 4'd1,
        PH_NUM1 = 4'd2,
        PH_FRC0 = 4'd3,
        PH_FRC1 = 4'd4,
        PH_EXPE = 4'd5,
        PH_EXPS = 4'd6,
        PH_EXP0 = 4'd7,
        PH_EXP1 = 4'd8
    } phase_t;

    // Status codes reported with the final character.
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_SYNTAX = 2'd1,
        ST_RANGE  = 2'd2
    } status_t;

    // Parser state carried from one character to the next.
    typedef struct packed {
        phase_t                  phase;
        logic                    negative;
        logic [COUNT_BITS-1:0]   count;
        logic [MAG_BITS-1:0]     scale;
        logic [MAG_BITS-1:0]     exponent;
        logic                    exp_negative;
        status_t                 error;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        phase:        PH_SKIP,
        negative:     1'b0,
        count:        '0,
        scale:        '0,
        exponent:     '0,
        exp_negative: 1'b0,
        error:        ST_OK
    };

    // One result item.
    typedef struct packed {
        logic               digit_valid;
        logic [3:0]         digit_value;
        logic               number_done;
        logic               is_negative;
        logic signed [15:0] scale_out;
        logic [15:0]        digit_count;
        status_t            status;
    } result_t;

endpackage

### hdl/dsbp_step.sv
// Combinational parse step: one character against the current parser state.
// Depends on dsbp_pkg for the state and result types and the character codes.
module dsbp_step (
    input  dsbp_pkg::parse_state_t cur_state,
    input  logic [7:0]             char_code,
    input  logic                   end_of_text,
    output dsbp_pkg::parse_state_t next_state,
    output dsbp_pkg::result_t      result
);

    always_comb
    begin
        dsbp_pkg::parse_state_t st;
        dsbp_pkg::phase_t       ph;
        logic                   done;
        logic                   is_dig;
        logic [7:0]             dig8;
        logic [3:0]             dig;
        logic                   emit_ok;
        logic [18:0]            exp_new;
        logic signed [16:0]     frac_s;
        logic signed [16:0]     exp_s;
        logic signed [16:0]     fin;
        logic [31:0]            cnt_ext;

        st       = cur_state;
        ph       = cur_state.phase;
        done     = 1'b0;
        is_dig   = (char_code >= dsbp_pkg::CHAR_ZERO) && (char_code <= dsbp_pkg::CHAR_NINE);
        dig8     = char_code - dsbp_pkg::CHAR_ZERO;
        dig      = dig8[3:0];
        emit_ok  = (cur_state.count != {dsbp_pkg::COUNT_BITS{1'b1}});
        exp_new  = ({4'b0, cur_state.exponent} << 3) + ({4'b0, cur_state.exponent} << 1)
                   + {15'b0, dig};
        result   = '0;

        // The grammar walk; a character may fall through several phases.
        if (cur_state.error == dsbp_pkg::ST_OK)
        begin
            if (ph == dsbp_pkg::PH_SKIP)
            begin
                if (char_code == dsbp_pkg::CHAR_ZERO)
                begin
                    done = 1'b1;
                end
                else if (char_code == dsbp_pkg::CHAR_MINUS)
                begin
                    st.negative = 1'b1;
                    st.phase    = dsbp_pkg::PH_NUM0;
                    done        = 1'b1;
                end
                else
                begin
                    ph = dsbp_pkg::PH_NUM0;
                end
            end

            if (!done && ph == dsbp_pkg::PH_NUM0)
            begin
                if (char_code == dsbp_pkg::CHAR_ZERO)
                begin
                    st.phase = dsbp_pkg::PH_NUM0;
                    done     = 1'b1;
                end
                else
                begin
                    ph = dsbp_pkg::PH_NUM1;
                end
            end

            // Integer digits.
            if (!done && ph == dsbp_pkg::PH_NUM1)
            begin
                st.phase = dsbp_pkg::PH_NUM1;
                if (is_dig)
                begin
                    done = 1'b1;
                    if (emit_ok)
                    begin
                        st.count           = cur_state.count + 1'b1;
                        result.digit_valid = 1'b1;
                        result.digit_value = dig;
                    end
                    else
                    begin
                        st.error = dsbp_pkg::ST_RANGE;
                    end
                end
                else if (char_code == dsbp_pkg::CHAR_POINT)
                begin
                    st.phase = (cur_state.count != '0) ? dsbp_pkg::PH_FRC1 : dsbp_pkg::PH_FRC0;
                    done     = 1'b1;
                end
                else
                begin
                    ph = dsbp_pkg::PH_EXPE;
                end
            end

            // Fraction digits; leading fraction zeros only raise the scale.
            if (!done && (ph == dsbp_pkg::PH_FRC0 || ph == dsbp_pkg::PH_FRC1))
            begin
                if (ph == dsbp_pkg::PH_FRC0 && char_code == dsbp_pkg::CHAR_ZERO)
                begin
                    done = 1'b1;
                    if (&cur_state.scale)
                        st.error = dsbp_pkg::ST_RANGE;
                    else
                        st.scale = cur_state.scale + 1'b1;
                end
                else
                begin
                    st.phase = dsbp_pkg::PH_FRC1;
                    if (is_dig)
                    begin
                        done = 1'b1;
                        if (&cur_state.scale)
                        begin
                            st.error = dsbp_pkg::ST_RANGE;
                        end
                        else
                        begin
                            st.scale = cur_state.scale + 1'b1;
                            if (emit_ok)
                            begin
                                st.count           = cur_state.count + 1'b1;
                                result.digit_valid = 1'b1;
                                result.digit_value = dig;
                            end
                            else
                            begin
                                st.error = dsbp_pkg::ST_RANGE;
                            end
                        end
                    end
                    else
                    begin
                        ph = dsbp_pkg::PH_EXPE;
                    end
                end
            end

            // Spaces, then the exponent marker.
            if (!done && ph == dsbp_pkg::PH_EXPE)
            begin
                st.phase = dsbp_pkg::PH_EXPE;
                done     = 1'b1;
                if (char_code == dsbp_pkg::CHAR_EXP)
                    st.phase = dsbp_pkg::PH_EXPS;
                else if (char_code != dsbp_pkg::CHAR_SPACE)
                    st.error = dsbp_pkg::ST_SYNTAX;
            end

            if (!done && ph == dsbp_pkg::PH_EXPS)
            begin
                st.phase = dsbp_pkg::PH_EXP0;
                if (char_code == dsbp_pkg::CHAR_MINUS)
                begin
                    st.exp_negative = 1'b1;
                    done            = 1'b1;
                end
                else
                begin
                    ph = dsbp_pkg::PH_EXP0;
                end
            end

            if (!done && ph == dsbp_pkg::PH_EXP0)
            begin
                if (char_code == dsbp_pkg::CHAR_ZERO)
                begin
                    st.phase = dsbp_pkg::PH_EXP0;
                    done     = 1'b1;
                end
                else
                begin
                    ph = dsbp_pkg::PH_EXP1;
                end
            end

            // Exponent digits, accumulated as exponent * 10 + digit.
            if (!done && ph == dsbp_pkg::PH_EXP1)
            begin
                st.phase = dsbp_pkg::PH_EXP1;
                done     = 1'b1;
                if (!is_dig)
                    st.error = dsbp_pkg::ST_SYNTAX;
                else if (|exp_new[18:15])
                    st.error = dsbp_pkg::ST_RANGE;
                else
                    st.exponent = exp_new[14:0];
            end

            // A phase code outside the grammar.
            if (!done)
                st.error = dsbp_pkg::ST_SYNTAX;
        end

        // Final scale and summary on the last character.
        frac_s  = {2'b00, st.scale};
        exp_s   = {2'b00, st.exponent};
        fin     = st.exp_negative ? (frac_s + exp_s) : (frac_s - exp_s);
        cnt_ext = 32'(st.count);

        if (end_of_text)
        begin
            result.number_done = 1'b1;
            result.digit_count = cnt_ext[15:0];
            if (st.error == dsbp_pkg::ST_OK)
            begin
                if (fin[16] != fin[15])
                begin
                    result.status = dsbp_pkg::ST_RANGE;
                end
                else
                begin
                    result.status = dsbp_pkg::ST_OK;
                    if (st.count != '0)
                    begin
                        result.scale_out   = fin[15:0];
                        result.is_negative = st.negative;
                    end
                end
            end
            else
            begin
                result.status = st.error;
            end
            next_state = dsbp_pkg::STATE_RESET;
        end
        else
        begin
            next_state = st;
        end
    end

endmodule

### hdl/decimal_string_to_bcd_parser_top.sv
// Top level of the decimal string to BCD parser: input register, parser state, result register.
// Depends on dsbp_pkg and dsbp_step.
//
// Each accepted character gives exactly one result item, one character per clock cycle
// sustained while out_stall is low, through the input register, then the result
// register. The rate is set by the parser state update, which the parse step computes
// combinationally between the input register and the result register. A result carries
// a BCD digit when the character is a significant digit, and on the character flagged
// end_of_text it also carries sign, scale, digit count and status; the parser then returns
// to its reset state for the next number. No clearing pass is needed after reset.
module decimal_string_to_bcd_parser_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               digit_valid,
    output logic [3:0]         digit_value,
    output logic               number_done,
    output logic               is_negative,
    output logic signed [15:0] scale_out,
    output logic [15:0]        digit_count,
    output logic [1:0]         status
);

    logic                   in_valid_reg;
    logic [7:0]             char_reg;
    logic                   eot_reg;
    logic                   out_valid_reg;
    dsbp_pkg::result_t      res_reg;
    dsbp_pkg::result_t      res_next;
    dsbp_pkg::parse_state_t state_reg;
    dsbp_pkg::parse_state_t state_next;
    logic                   advance;
    logic                   in_take;

    // Handshake: the held character moves on whenever the result register is free.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            char_reg <= char_code;
            eot_reg  <= end_of_text;
        end
    end

    // Parse step for the held character.
    dsbp_step u_step (
        .cur_state   (state_reg),
        .char_code   (char_reg),
        .end_of_text (eot_reg),
        .next_state  (state_next),
        .result      (res_next)
    );

    // Parser state, updated once per transfer into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dsbp_pkg::STATE_RESET;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign digit_valid = res_reg.digit_valid;
    assign digit_value = res_reg.digit_value;
    assign number_done = res_reg.number_done;
    assign is_negative = res_reg.is_negative;
    assign scale_out   = res_reg.scale_out;
    assign digit_count = res_reg.digit_count;
    assign status      = res_reg.status;

    // The parser starts over after the last character of a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && eot_reg) |=> (state_reg.phase == dsbp_pkg::PH_SKIP
                                  && state_reg.count == '0
                                  && state_reg.error == dsbp_pkg::ST_OK))
        else $error("parser state not cleared after end of text");

    // An emitted digit is always a decimal digit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.digit_valid) |-> (res_reg.digit_value <= 4'd9))
        else $error("emitted digit is not a BCD digit");

    // Summary fields stay zero on results that do not end a number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_reg.number_done) |->
            (res_reg.status == dsbp_pkg::ST_OK && res_reg.digit_count == '0
             && res_reg.scale_out == '0 && !res_reg.is_negative))
        else $error("summary fields set on a result that does not end a number");

    // A failed number reports neither sign nor scale.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.status != dsbp_pkg::ST_OK) |->
            (res_reg.scale_out == '0 && !res_reg.is_negative))
        else $error("sign or scale reported with an error status");

    // Once an error is recorded, no further digit leaves the parser for that number.
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && state_reg.error != dsbp_pkg::ST_OK) |-> !res_next.digit_valid)
        else $error("digit emitted after a sticky error");

endmodule

### bench/dsbp_result_checker.sv
// Result checker for the decimal string parser bench: it follows every character transfer,
// works out the result item that the parser must give, and compares it with the delivered one.
// Depends on dsbp_pkg for the character codes, phases, status codes and item types.
module dsbp_result_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         char_code,
    input  logic               end_of_text,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic               digit_valid,
    input  logic [3:0]         digit_value,
    input  logic               number_done,
    input  logic               is_negative,
    input  logic signed [15:0] scale_out,
    input  logic [15:0]        digit_count,
    input  logic [1:0]         status,
    output int                 fail_count,
    output int                 backlog,
    output int                 chars_taken,
    output int                 numbers_seen,
    output int                 digits_seen,
    output int                 syntax_seen,
    output int                 range_seen
);
    import dsbp_pkg::*;

    // Parser state as the bench sees it, and the results still owed by the block.
    parse_state_t parser = STATE_RESET;
    result_t      pending_bcd_results[$];
    result_t      want;
    result_t      got;
    int           fails;
    int           reported;
    int           taken;
    int           numbers;
    int           digits;
    int           syntax_errs;
    int           range_errs;

    // Raises the fraction scale; at the 15-bit limit the number goes out of range.
    function automatic bit bump_scale();
        if (parser.scale == '1)
        begin
            parser.error = ST_RANGE;
            return 1'b0;
        end
        parser.scale = parser.scale + 1'b1;
        return 1'b1;
    endfunction

    // Counts one significant digit unless the counter is already full.
    function automatic bit take_digit();
        if (parser.count == '1)
        begin
            parser.error = ST_RANGE;
            return 1'b0;
        end
        parser.count = parser.count + 1'b1;
        return 1'b1;
    endfunction

    // Advances the parser by one character and queues the result item it must produce.
    task automatic parse_char(input logic [7:0] c, input logic last);
        result_t  r;
        phase_t   ph;
        bit       used;
        bit       is_dig;
        int       nv;
        int       fin;
        r = '0;
        used = 1'b0;
        is_dig = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        ph = parser.phase;
        if (parser.error != ST_OK)
            used = 1'b1;

        // Leading zeros and the sign.
        if (!used && ph == PH_SKIP)
        begin
            if (c == CHAR_ZERO)
                used = 1'b1;
            else if (c == CHAR_MINUS)
            begin
                parser.negative = 1'b1;
                parser.phase = PH_NUM0;
                used = 1'b1;
            end
            else
                ph = PH_NUM0;
        end
        if (!used && ph == PH_NUM0)
        begin
            if (c == CHAR_ZERO)
            begin
                parser.phase = PH_NUM0;
                used = 1'b1;
            end
            else
                ph = PH_NUM1;
        end

        // Integer digits, then the fraction; anything else falls through to the exponent marker.
        if (!used && ph == PH_NUM1)
        begin
            parser.phase = PH_NUM1;
            if (is_dig)
            begin
                if (take_digit())
                begin
                    r.digit_valid = 1'b1;
                    r.digit_value = 4'(c - CHAR_ZERO);
                end
                used = 1'b1;
            end
            else if (c == CHAR_POINT)
            begin
                parser.phase = (parser.count != 0) ? PH_FRC1 : PH_FRC0;
                used = 1'b1;
            end
            else
                ph = PH_EXPE;
        end
        else if (!used && (ph == PH_FRC0 || ph == PH_FRC1))
        begin
            if (ph == PH_FRC0 && c == CHAR_ZERO)
            begin
                void'(bump_scale());
                used = 1'b1;
            end
            else
            begin
                parser.phase = PH_FRC1;
                if (is_dig)
                begin
                    if (bump_scale() && take_digit())
                    begin
                        r.digit_valid = 1'b1;
                        r.digit_value = 4'(c - CHAR_ZERO);
                    end
                    used = 1'b1;
                end
                else
                    ph = PH_EXPE;
            end
        end

        // Spaces and the exponent marker.
        if (!used && ph == PH_EXPE)
        begin
            parser.phase = PH_EXPE;
            if (c == CHAR_EXP)
                parser.phase = PH_EXPS;
            else if (c != CHAR_SPACE)
                parser.error = ST_SYNTAX;
            used = 1'b1;
        end

        // Exponent sign, its leading zeros and its digits.
        if (!used && ph == PH_EXPS)
        begin
            parser.phase = PH_EXP0;
            if (c == CHAR_MINUS)
            begin
                parser.exp_negative = 1'b1;
                used = 1'b1;
            end
            else
                ph = PH_EXP0;
        end
        if (!used && ph == PH_EXP0)
        begin
            if (c == CHAR_ZERO)
            begin
                parser.phase = PH_EXP0;
                used = 1'b1;
            end
            else
                ph = PH_EXP1;
        end
        if (!used && ph == PH_EXP1)
        begin
            parser.phase = PH_EXP1;
            if (is_dig)
            begin
                nv = int'(parser.exponent) * 10 + int'(c) - int'(CHAR_ZERO);
                if (nv > 32767)
                    parser.error = ST_RANGE;
                else
                    parser.exponent = 15'(nv);
            end
            else
                parser.error = ST_SYNTAX;
            used = 1'b1;
        end
        if (!used)
            parser.error = ST_SYNTAX;

        // The final character reports the whole number and starts a fresh one.
        if (last)
        begin
            r.number_done = 1'b1;
            if (parser.error == ST_OK)
            begin
                if (parser.exp_negative)
                    fin = int'(parser.scale) + int'(parser.exponent);
                else
                    fin = int'(parser.scale) - int'(parser.exponent);
                if (fin > 32767 || fin < -32768)
                    parser.error = ST_RANGE;
                else if (parser.count != 0)
                begin
                    r.is_negative = parser.negative;
                    r.scale_out = 16'(fin);
                end
            end
            r.digit_count = parser.count;
            r.status = parser.error;
            parser = STATE_RESET;
        end
        pending_bcd_results = {pending_bcd_results, r};
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parser = STATE_RESET;
            pending_bcd_results.delete();
        end
        else
        begin
            // Result transfer: compare with the oldest expectation.
            if (out_valid && !out_stall)
            begin
                got.digit_valid = digit_valid;
                got.digit_value = digit_value;
                got.number_done = number_done;
                got.is_negative = is_negative;
                got.scale_out   = scale_out;
                got.digit_count = digit_count;
                got.status      = status_t'(status);
                if (got.number_done)
                begin
                    numbers++;
                    if (got.status == ST_SYNTAX)
                        syntax_errs++;
                    if (got.status == ST_RANGE)
                        range_errs++;
                end
                if (got.digit_valid)
                    digits++;
                if (pending_bcd_results.size() == 0)
                begin
                    fails++;
                    if (reported < 10)
                        $display("unexpected result item at %0t", $realtime);
                    reported++;
                end
                else
                begin
                    want = pending_bcd_results.pop_front();
                    if (got.digit_valid != want.digit_valid ||
                        got.digit_value != want.digit_value ||
                        got.number_done != want.number_done ||
                        got.is_negative != want.is_negative ||
                        got.scale_out   != want.scale_out   ||
                        got.digit_count != want.digit_count ||
                        got.status      != want.status)
                    begin
                        fails++;
                        if (reported < 10)
                        begin
                            $display("result mismatch at %0t", $realtime);
                            $display({"  expected dv=%0d d=%0d done=%0d neg=%0d",
                                      " scale=%0d cnt=%0d st=%0d"},
                                     want.digit_valid, want.digit_value, want.number_done,
                                     want.is_negative, want.scale_out, want.digit_count,
                                     want.status);
                            $display({"  actual   dv=%0d d=%0d done=%0d neg=%0d",
                                      " scale=%0d cnt=%0d st=%0d"},
                                     got.digit_valid, got.digit_value, got.number_done,
                                     got.is_negative, got.scale_out, got.digit_count,
                                     got.status);
                        end
                        reported++;
                    end
                end
            end

            // Character transfer: predict the result it causes.
            if (in_valid && !in_stall)
            begin
                parse_char(char_code, end_of_text);
                taken++;
            end

            fail_count   <= fails;
            backlog      <= pending_bcd_results.size();
            chars_taken  <= taken;
            numbers_seen <= numbers;
            digits_seen  <= digits;
            syntax_seen  <= syntax_errs;
            range_seen   <= range_errs;
        end
    end

endmodule

### bench/decimal_string_to_bcd_parser_top_tb.sv
// Testbench top for decimal_string_to_bcd_parser_top: sends number texts with random gaps
// and result stalls, and gives the verdict from the result checker's failure count.
// Depends on dsbp_pkg, the parser RTL and bench/dsbp_result_checker.sv.
module decimal_string_to_bcd_parser_top_tb;
    import dsbp_pkg::*;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         char_code;
    logic               end_of_text;
    logic               out_valid;
    logic               out_stall;
    logic               digit_valid;
    logic [3:0]         digit_value;
    logic               number_done;
    logic               is_negative;
    logic signed [15:0] scale_out;
    logic [15:0]        digit_count;
    logic [1:0]         status;

    int   fail_count;
    int   backlog;
    int   chars_taken;
    int   numbers_seen;
    int   digits_seen;
    int   syntax_seen;
    int   range_seen;

    logic       no_idle;
    logic [7:0] text_buf[$];
    int         chars_sent;
    int         hold_left;
    int         next_hold;
    int         quiet_cycles;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    decimal_string_to_bcd_parser_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .digit_valid (digit_valid),
        .digit_value (digit_value),
        .number_done (number_done),
        .is_negative (is_negative),
        .scale_out   (scale_out),
        .digit_count (digit_count),
        .status      (status)
    );

    dsbp_result_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_code    (char_code),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .digit_valid  (digit_valid),
        .digit_value  (digit_value),
        .number_done  (number_done),
        .is_negative  (is_negative),
        .scale_out    (scale_out),
        .digit_count  (digit_count),
        .status       (status),
        .fail_count   (fail_count),
        .backlog      (backlog),
        .chars_taken  (chars_taken),
        .numbers_seen (numbers_seen),
        .digits_seen  (digits_seen),
        .syntax_seen  (syntax_seen),
        .range_seen   (range_seen)
    );

    // Wait before the next transfer on either side; often zero, never while no_idle is set.
    function automatic int pick_wait();
        if (no_idle || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 13);
    endfunction

    // Result side: after each transfer, hold stall high for a freshly drawn number of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            next_hold = pick_wait();
            hold_left <= next_hold;
            out_stall <= (next_hold != 0);
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= (hold_left != 1);
        end
    end

    // Watchdog: the run ends if neither channel moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles == STALL_LIMIT)
            begin
                $display("[decimal_string_to_bcd_parser_top] ERROR");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offers one character after a random gap and returns right after its transfer.
    task automatic send_char(input logic [7:0] c, input logic last);
        int gap;
        gap = pick_wait();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        char_code   <= c;
        end_of_text <= last;
        do
            @(posedge clk);
        while (in_stall);
        chars_sent++;
    endtask

    // Appends one byte to the text under construction.
    task automatic put_char(input logic [7:0] c);
        text_buf = {text_buf, c};
    endtask

    task automatic add_str(input string s);
        for (int i = 0; i < s.len(); i++)
            put_char(s[i]);
    endtask

    // Sends the assembled text, marking its last character as the end of the number.
    task automatic send_buf();
        if (text_buf.size() == 0)
            put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        for (int i = 0; i < text_buf.size(); i++)
            send_char(text_buf[i], i == text_buf.size() - 1);
        text_buf.delete();
    endtask

    task automatic send_text(input string s);
        add_str(s);
        send_buf();
    endtask

    // A well-formed number with random content in every part of the grammar.
    task automatic build_number();
        int ev;
        repeat ($urandom_range(0, 2)) put_char(CHAR_ZERO);
        if ($urandom_range(0, 1) != 0)
            put_char(CHAR_MINUS);
        repeat ($urandom_range(0, 2)) put_char(CHAR_ZERO);
        repeat ($urandom_range(0, 4)) put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0)
        begin
            put_char(CHAR_POINT);
            repeat ($urandom_range(0, 3)) put_char(CHAR_ZERO);
            repeat ($urandom_range(0, 4))
                put_char(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 2)) put_char(CHAR_SPACE);
        if ($urandom_range(0, 2) != 0)
        begin
            put_char(CHAR_EXP);
            if ($urandom_range(0, 1) != 0)
                put_char(CHAR_MINUS);
            repeat ($urandom_range(0, 2)) put_char(CHAR_ZERO);
            // Exponents near and past the 15-bit limit, or none at all.
            case ($urandom_range(0, 5))
                0:       ev = $urandom_range(32760, 32767);
                1:       ev = $urandom_range(32768, 99999);
                2:       ev = -1;
                default: ev = $urandom_range(0, 999);
            endcase
            if (ev >= 0)
                add_str($sformatf("%0d", ev));
        end
    endtask

    // Short junk: any byte, or grammar characters in the wrong order.
    task automatic build_noise();
        logic [7:0] picks[7];
        picks = '{CHAR_ZERO, CHAR_NINE, CHAR_MINUS, CHAR_POINT, CHAR_EXP, CHAR_SPACE, 8'h35};
        repeat ($urandom_range(1, 5))
        begin
            if ($urandom_range(0, 1) != 0)
                put_char(8'($urandom_range(0, 255)));
            else
                put_char(picks[$urandom_range(0, 6)]);
        end
    endtask

    initial
    begin
        int random_start;
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        char_code   <= 8'h00;
        end_of_text <= 1'b0;
        no_idle     <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed texts: sign, fraction zeros, negative exponent, spaces, bare zero,
        // no digits, truncated sign and exponent, sticky syntax error, byte extremes.
        send_text("-00.05E-3");
        send_text("12.5 E2");
        send_text("0");
        send_text("E");
        send_text("-");
        send_text("3E-");
        send_text("1x9");
        send_char(8'hFF, 1'b1);
        send_char(8'h00, 1'b1);

        // Random texts: mostly well-formed numbers, some corrupted, some pure noise.
        random_start = chars_sent;
        while (chars_sent - random_start < 680)
        begin
            if ($urandom_range(0, 7) == 0)
                no_idle <= !no_idle;
            if ($urandom_range(0, 4) == 0)
                build_noise();
            else
                build_number();
            if (text_buf.size() != 0 && $urandom_range(0, 5) == 0)
                text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
            send_buf();
        end

        // Drain: wait for every owed result, then wait on for anything stray.
        in_valid <= 1'b0;
        @(posedge clk);
        while (backlog != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);

        $display("Run covered %0d characters, %0d numbers and %0d significant digits.",
                 chars_taken, numbers_seen, digits_seen);
        $display("Numbers with syntax errors: %0d, out of range: %0d, failures: %0d.",
                 syntax_seen, range_seen, fail_count);
        if (fail_count == 0 && backlog == 0)
            $display("[decimal_string_to_bcd_parser_top] OK");
        else
            $display("[decimal_string_to_bcd_parser_top] ERROR");
        $finish;
    end

endmodule

### decimal_string_to_bcd_parser_top.f
hdl/dsbp_pkg.sv
hdl/dsbp_step.sv
hdl/decimal_string_to_bcd_parser_top.sv
bench/dsbp_result_checker.sv
bench/decimal_string_to_bcd_parser_top_tb.sv
